/* rtl/glc_pkg.sv */
// ----------------------------------------------------------------------------
// glc_pkg
// Shared widths, register indexes, opcodes and constants for the grid
// line-of-sight checker.
// ----------------------------------------------------------------------------
package glc_pkg;

    localparam int MAX_GRID_WIDTH_DEF  = 256;
    localparam int MAX_GRID_HEIGHT_DEF = 256;

    localparam int COORD_W   = 12;
    localparam int CELL_W    = 8;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int DIM_W     = 12;
    localparam int ERR_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic signed [CELL_W-1:0] OCCUPIED_VALUE = 8'sd100;

    localparam logic [CFG_W-1:0] GRID_DIM_RESET = 9'd256;

endpackage

/* rtl/glc_grid_mem.sv */
// ----------------------------------------------------------------------------
// glc_grid_mem
// One-bit occupancy store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module glc_grid_mem #(
    parameter int AW = 16
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic          rdata
);

    logic mem [2**AW];
    logic rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/grid_line_of_sight_check.sv */
// ----------------------------------------------------------------------------
// grid_line_of_sight_check
// Write item: no result. Query item: one grid cell per cycle along the
// line, after a setup step and followed by a result load.
// The walk is set by the single grid memory read port, one read per step.
// After reset a clearing pass over all 2**(XW+YW) cells (65536 at the defaults)
// frees every cell; no item is accepted meanwhile, config writes are taken.
// ----------------------------------------------------------------------------
module grid_line_of_sight_check #(
    parameter int MAX_GRID_WIDTH  = glc_pkg::MAX_GRID_WIDTH_DEF,
    parameter int MAX_GRID_HEIGHT = glc_pkg::MAX_GRID_HEIGHT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [glc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [glc_pkg::CFG_W-1:0]           cfg_wr_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_opcode,
    input  logic [glc_pkg::CELL_W-1:0]          s_cell_x,
    input  logic [glc_pkg::CELL_W-1:0]          s_cell_y,
    input  logic signed [glc_pkg::CELL_W-1:0]   s_cell_value,
    input  logic signed [glc_pkg::COORD_W-1:0]  s_start_x,
    input  logic signed [glc_pkg::COORD_W-1:0]  s_start_y,
    input  logic signed [glc_pkg::COORD_W-1:0]  s_end_x,
    input  logic signed [glc_pkg::COORD_W-1:0]  s_end_y,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_blocked
);

    localparam int XW = $clog2(MAX_GRID_WIDTH);
    localparam int YW = $clog2(MAX_GRID_HEIGHT);
    localparam int AW = XW + YW;
    localparam int CW = glc_pkg::COORD_W;
    localparam int DW = glc_pkg::DIM_W;
    localparam int EW = glc_pkg::ERR_W;
    localparam logic [DW-1:0] MAX_W_DIM = DW'(MAX_GRID_WIDTH);
    localparam logic [DW-1:0] MAX_H_DIM = DW'(MAX_GRID_HEIGHT);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SETUP = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_LAST  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]                 state_reg, state_next;
    logic [AW-1:0]              clr_cnt_reg, clr_cnt_next;
    logic [glc_pkg::CFG_W-1:0]  grid_width_reg, grid_height_reg;

    logic signed [CW-1:0]       x_reg, x_next, y_reg, y_next;
    logic signed [CW-1:0]       xe_reg, xe_next, ye_reg, ye_next;
    logic signed [CW:0]         dx_reg, dx_next, dy_reg, dy_next;
    logic                       sx_neg_reg, sx_neg_next, sy_neg_reg, sy_neg_next;
    logic signed [EW-1:0]       err_reg, err_next;
    logic                       pend_reg, pend_next;
    logic                       res_reg, res_next;
    logic                       m_valid_reg, m_valid_next;
    logic                       m_blocked_reg, m_blocked_next;

    logic                       in_acc;
    logic signed [CW:0]         diff_x, diff_y;
    logic [DW-1:0]              w_eff, h_eff;
    logic [DW-1:0]              cx_ext, cy_ext;
    logic                       oob, at_end, step_x, step_y;
    logic signed [EW-1:0]       e2, dx_e, dy_e;

    logic                       mem_we, mem_wdata, mem_re, mem_rdata;
    logic [AW-1:0]              mem_waddr, mem_raddr;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_blocked = m_blocked_reg;

    assign w_eff = ({3'b000, grid_width_reg} > MAX_W_DIM) ? MAX_W_DIM
                                                          : {3'b000, grid_width_reg};
    assign h_eff = ({3'b000, grid_height_reg} > MAX_H_DIM) ? MAX_H_DIM
                                                           : {3'b000, grid_height_reg};

    assign cx_ext = {4'b0000, s_cell_x};
    assign cy_ext = {4'b0000, s_cell_y};

    assign diff_x = {s_end_x[CW-1], s_end_x} - {s_start_x[CW-1], s_start_x};
    assign diff_y = {s_end_y[CW-1], s_end_y} - {s_start_y[CW-1], s_start_y};

    assign oob    = x_reg[CW-1] || y_reg[CW-1] ||
                    ($unsigned(x_reg) >= w_eff) || ($unsigned(y_reg) >= h_eff);
    assign at_end = (x_reg == xe_reg) && (y_reg == ye_reg);

    assign e2     = err_reg <<< 1;
    assign dx_e   = EW'(dx_reg);
    assign dy_e   = EW'(dy_reg);
    assign step_x = (e2 >= dy_e);
    assign step_y = (e2 <= dx_e);

    assign mem_raddr = {y_reg[YW-1:0], x_reg[XW-1:0]};

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        xe_next        = xe_reg;
        ye_next        = ye_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sx_neg_next    = sx_neg_reg;
        sy_neg_next    = sy_neg_reg;
        err_next       = err_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_blocked_next = m_blocked_reg;
        mem_we         = 1'b0;
        mem_waddr      = {cy_ext[YW-1:0], cx_ext[XW-1:0]};
        mem_wdata      = (s_cell_value == glc_pkg::OCCUPIED_VALUE);
        mem_re         = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = 1'b0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_opcode == glc_pkg::OP_WRITE) begin
                        mem_we = (cx_ext < MAX_W_DIM) && (cy_ext < MAX_H_DIM);
                    end else begin
                        x_next      = s_start_x;
                        y_next      = s_start_y;
                        xe_next     = s_end_x;
                        ye_next     = s_end_y;
                        dx_next     = diff_x[CW] ? -diff_x : diff_x;
                        dy_next     = diff_y[CW] ? diff_y : -diff_y;
                        sx_neg_next = !(s_start_x < s_end_x);
                        sy_neg_next = !(s_start_y < s_end_y);
                        state_next  = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                err_next   = dx_e + dy_e;
                pend_next  = 1'b0;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if ((pend_reg && mem_rdata) || oob) begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end else if (at_end) begin
                    mem_re     = 1'b1;
                    state_next = ST_LAST;
                end else begin
                    mem_re    = 1'b1;
                    pend_next = 1'b1;
                    err_next  = err_reg + (step_x ? dy_e : '0) + (step_y ? dx_e : '0);
                    if (step_x) begin
                        x_next = sx_neg_reg ? x_reg - 1'b1 : x_reg + 1'b1;
                    end
                    if (step_y) begin
                        y_next = sy_neg_reg ? y_reg - 1'b1 : y_reg + 1'b1;
                    end
                end
            end
            ST_LAST: begin
                res_next   = mem_rdata;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_blocked_next = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
            pend_reg        <= 1'b0;
            grid_width_reg  <= glc_pkg::GRID_DIM_RESET;
            grid_height_reg <= glc_pkg::GRID_DIM_RESET;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
            if (cfg_wr_en && (cfg_index == glc_pkg::CFG_GRID_WIDTH)) begin
                grid_width_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && (cfg_index == glc_pkg::CFG_GRID_HEIGHT)) begin
                grid_height_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        xe_reg        <= xe_next;
        ye_reg        <= ye_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        sx_neg_reg    <= sx_neg_next;
        sy_neg_reg    <= sy_neg_next;
        err_reg       <= err_next;
        res_reg       <= res_next;
        m_blocked_reg <= m_blocked_next;
    end

    glc_grid_mem #(
        .AW (AW)
    ) u_grid_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

/* rtl/glc_checker.sv */
// ----------------------------------------------------------------------------
// glc_checker
// Port-level checks for the grid line-of-sight checker, bound to the top.
// ----------------------------------------------------------------------------
module glc_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_opcode,
    input logic m_valid,
    input logic m_ready,
    input logic m_blocked
);

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_blocked))
        else $error("result item changed while stalled");

    // a write item never produces a result
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_opcode == glc_pkg::OP_WRITE) && !m_valid
        |=> !m_valid)
        else $error("result after a write item");

    // a query keeps the block busy
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_opcode == glc_pkg::OP_QUERY) |=> !s_ready)
        else $error("ready right after a query item");

    // clearing pass runs right after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_ready && !m_valid)
        else $error("item path open at end of reset");

endmodule

bind grid_line_of_sight_check glc_checker u_glc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_opcode  (s_opcode),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_blocked (m_blocked)
);

/* sim/grid_line_of_sight_check_tb.sv */
// ----------------------------------------------------------------------------
// grid_line_of_sight_check_tb
// Self-checking bench for the grid line-of-sight checker. A queue-fed driver
// offers write and query items with random gaps. A monitor takes blocked
// flags with random stalls and one long hold-off. A local occupancy grid and
// a Bresenham walker predict each query answer in order. The grid size is
// changed between phases, including zero, one and saturating sizes.
// ----------------------------------------------------------------------------
module grid_line_of_sight_check_tb;

    typedef logic [glc_pkg::CFG_IDX_W-1:0]      idx_t;
    typedef logic [glc_pkg::CFG_W-1:0]          cfg_t;
    typedef logic [glc_pkg::CELL_W-1:0]         cell_t;
    typedef logic signed [glc_pkg::CELL_W-1:0]  cval_t;
    typedef logic signed [glc_pkg::COORD_W-1:0] coord_t;

    localparam int GRID_COLS    = glc_pkg::MAX_GRID_WIDTH_DEF;
    localparam int GRID_ROWS    = glc_pkg::MAX_GRID_HEIGHT_DEF;
    localparam int STALL_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 150;
    localparam int DRAIN_CYCLES = 300;
    localparam int SETTLE_GAP   = 8;
    localparam int MAX_REPORTS  = 10;

    localparam idx_t CFG_UNUSED_A = idx_t'(2);
    localparam idx_t CFG_UNUSED_B = idx_t'(3);

    typedef struct {
        logic   opcode;
        cell_t  cell_x;
        cell_t  cell_y;
        cval_t  cell_value;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } grid_item_t;

    logic   aclk         = 1'b0;
    logic   aresetn      = 1'b0;
    logic   cfg_wr_en    = 1'b0;
    idx_t   cfg_index    = '0;
    cfg_t   cfg_wr_data  = '0;
    logic   s_valid      = 1'b0;
    logic   s_ready;
    logic   s_opcode     = glc_pkg::OP_WRITE;
    cell_t  s_cell_x     = '0;
    cell_t  s_cell_y     = '0;
    cval_t  s_cell_value = '0;
    coord_t s_start_x    = '0;
    coord_t s_start_y    = '0;
    coord_t s_end_x      = '0;
    coord_t s_end_y      = '0;
    logic   m_valid;
    logic   m_ready      = 1'b0;
    logic   m_blocked;

    // local copy of the block state
    bit     occ_map [GRID_COLS*GRID_ROWS];
    cfg_t   width_reg  = glc_pkg::GRID_DIM_RESET;
    cfg_t   height_reg = glc_pkg::GRID_DIM_RESET;

    grid_item_t pending_items [$];
    grid_item_t cur_item;
    bit         blocked_q [$];
    bit         expected_blocked;

    int items_pushed   = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int fail_count     = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int quiet_cycles   = 0;

    grid_line_of_sight_check u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_cell_x     (s_cell_x),
        .s_cell_y     (s_cell_y),
        .s_cell_value (s_cell_value),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_blocked    (m_blocked)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic int used_cols();
        return (width_reg > GRID_COLS) ? GRID_COLS : int'(width_reg);
    endfunction

    function automatic int used_rows();
        return (height_reg > GRID_ROWS) ? GRID_ROWS : int'(height_reg);
    endfunction

    function automatic bit line_blocked(int x, int y, int xe, int ye);
        int w;
        int h;
        int dx;
        int dy;
        int step_x;
        int step_y;
        int err;
        int e2;
        w      = used_cols();
        h      = used_rows();
        dx     = (xe > x) ? xe - x : x - xe;
        dy     = (ye > y) ? y - ye : ye - y;
        step_x = (x < xe) ? 1 : -1;
        step_y = (y < ye) ? 1 : -1;
        err    = dx + dy;
        while (1) begin
            if (x < 0 || y < 0 || x >= w || y >= h) begin
                return 1'b1;
            end
            if (occ_map[y*GRID_COLS + x]) begin
                return 1'b1;
            end
            if (x == xe && y == ye) begin
                return 1'b0;
            end
            e2 = 2 * err;
            if (e2 >= dy) begin
                err += dy;
                x   += step_x;
            end
            if (e2 <= dx) begin
                err += dx;
                y   += step_y;
            end
        end
    endfunction

    function automatic void apply_item(grid_item_t it);
        if (it.opcode == glc_pkg::OP_WRITE) begin
            occ_map[int'(it.cell_y)*GRID_COLS + int'(it.cell_x)] =
                (it.cell_value == glc_pkg::OCCUPIED_VALUE);
        end else begin
            blocked_q.insert(blocked_q.size(),
                             line_blocked(int'(it.start_x), int'(it.start_y),
                                          int'(it.end_x), int'(it.end_y)));
        end
    endfunction

    // ------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------
    function automatic grid_item_t random_fields();
        grid_item_t it;
        it.opcode     = 1'($urandom_range(1));
        it.cell_x     = cell_t'($urandom);
        it.cell_y     = cell_t'($urandom);
        it.cell_value = cval_t'($urandom);
        it.start_x    = coord_t'($urandom);
        it.start_y    = coord_t'($urandom);
        it.end_x      = coord_t'($urandom);
        it.end_y      = coord_t'($urandom);
        return it;
    endfunction

    function automatic grid_item_t make_write(int x, int y, int value);
        grid_item_t it;
        it            = random_fields();
        it.opcode     = glc_pkg::OP_WRITE;
        it.cell_x     = cell_t'(x);
        it.cell_y     = cell_t'(y);
        it.cell_value = cval_t'(value);
        return it;
    endfunction

    function automatic grid_item_t make_query(int x0, int y0, int x1, int y1);
        grid_item_t it;
        it         = random_fields();
        it.opcode  = glc_pkg::OP_QUERY;
        it.start_x = coord_t'(x0);
        it.start_y = coord_t'(y0);
        it.end_x   = coord_t'(x1);
        it.end_y   = coord_t'(y1);
        return it;
    endfunction

    // mostly short lines inside a window where writes land, some wild ones
    function automatic grid_item_t random_item(int w, int h, int span);
        grid_item_t it;
        int roll;
        int ww;
        int hh;
        int x0;
        int y0;
        ww   = (w < span) ? w : span;
        hh   = (h < span) ? h : span;
        it   = random_fields();
        roll = int'($urandom_range(99));
        if (roll < 40) begin
            it.opcode = glc_pkg::OP_WRITE;
            if ($urandom_range(99) < 85) begin
                it.cell_x = cell_t'($urandom_range(ww - 1));
                it.cell_y = cell_t'($urandom_range(hh - 1));
            end
            if ($urandom_range(99) < 45) begin
                it.cell_value = glc_pkg::OCCUPIED_VALUE;
            end
        end else begin
            it.opcode = glc_pkg::OP_QUERY;
            roll = int'($urandom_range(99));
            if (roll < 95) begin
                x0         = int'($urandom_range(ww - 1));
                y0         = int'($urandom_range(hh - 1));
                it.start_x = coord_t'(x0);
                it.start_y = coord_t'(y0);
                if (roll < 85) begin
                    it.end_x = coord_t'(x0 + int'($urandom_range(span)) - span / 2);
                    it.end_y = coord_t'(y0 + int'($urandom_range(span)) - span / 2);
                end
            end
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // sequencing helpers
    // ------------------------------------------------------------------
    task automatic enqueue(grid_item_t it);
        pending_items.insert(pending_items.size(), it);
        items_pushed++;
    endtask

    task automatic write_reg(idx_t idx, cfg_t val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        if (idx == glc_pkg::CFG_GRID_WIDTH) begin
            width_reg = val;
        end else if (idx == glc_pkg::CFG_GRID_HEIGHT) begin
            height_reg = val;
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (!(items_accepted == items_pushed && blocked_q.size() == 0)) begin
            @(negedge aclk);
        end
        repeat (SETTLE_GAP) @(posedge aclk);
    endtask

    task automatic run_random(int count, int span);
        int w;
        int h;
        w = used_cols();
        h = used_rows();
        for (int i = 0; i < count; i++) begin
            enqueue(random_item(w, h, span));
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_item(cur_item);
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 &&
                    !((items_accepted < 300 || items_accepted >= 450) &&
                      $urandom_range(99) < 6)) begin
                    cur_item      = pending_items.pop_front();
                    s_valid      <= 1'b1;
                    s_opcode     <= cur_item.opcode;
                    s_cell_x     <= cur_item.cell_x;
                    s_cell_y     <= cur_item.cell_y;
                    s_cell_value <= cur_item.cell_value;
                    s_start_x    <= cur_item.start_x;
                    s_start_y    <= cur_item.start_y;
                    s_end_x      <= cur_item.end_x;
                    s_end_y      <= cur_item.end_y;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (blocked_q.size() == 0) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("unexpected result: blocked=%0b, nothing expected",
                                 m_blocked);
                    end
                    fail_count++;
                end else begin
                    expected_blocked = blocked_q.pop_front();
                    if (m_blocked !== expected_blocked) begin
                        if (fail_count < MAX_REPORTS) begin
                            $display("blocked mismatch at result %0d: expected %0b, got %0b",
                                     results_seen, expected_blocked, m_blocked);
                        end
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                // long hold-off so the block backs up into its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready  <= 1'b0;
            end else begin
                m_ready <= !((results_seen < 180 || results_seen >= 280) &&
                             $urandom_range(99) < 6);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        write_reg(glc_pkg::CFG_GRID_WIDTH, 9'd256);
        write_reg(glc_pkg::CFG_GRID_HEIGHT, 9'd256);

        // directed: full grid
        enqueue(make_query(0, 0, 0, 0));
        enqueue(make_write(0, 0, 100));
        enqueue(make_query(0, 0, 0, 0));
        enqueue(make_write(0, 0, 99));
        enqueue(make_query(0, 0, 3, 0));
        enqueue(make_write(255, 255, 100));
        enqueue(make_query(0, 0, 255, 255));
        enqueue(make_query(255, 0, 0, 255));
        enqueue(make_write(7, 3, 127));
        enqueue(make_write(7, 3, -128));
        enqueue(make_query(-1, 0, 5, 5));
        enqueue(make_query(0, -2048, 0, 0));
        enqueue(make_query(2047, 2047, 0, 0));
        enqueue(make_query(10, 10, -2048, 2047));
        enqueue(make_query(250, 10, 300, 10));
        enqueue(make_write(255, 255, 0));
        enqueue(make_query(255, 255, 255, 255));
        enqueue(make_write(20, 5, 100));
        enqueue(make_query(0, 0, 40, 10));
        enqueue(make_query(40, 10, 0, 0));
        wait_idle();

        // zero width, then zero height
        write_reg(glc_pkg::CFG_GRID_WIDTH, 9'd0);
        enqueue(make_query(0, 0, 0, 0));
        enqueue(make_query(3, 3, 10, 1));
        wait_idle();
        write_reg(glc_pkg::CFG_GRID_WIDTH, 9'd256);
        write_reg(glc_pkg::CFG_GRID_HEIGHT, 9'd0);
        enqueue(make_query(5, 0, 5, 0));
        wait_idle();

        // saturated width, single row
        write_reg(glc_pkg::CFG_GRID_WIDTH, 9'h1FF);
        write_reg(glc_pkg::CFG_GRID_HEIGHT, 9'd1);
        enqueue(make_query(0, 0, 255, 0));
        enqueue(make_query(0, 0, 0, 1));
        enqueue(make_query(255, 0, 256, 0));
        enqueue(make_write(100, 0, 100));
        enqueue(make_query(0, 0, 255, 0));
        wait_idle();

        // unused register indexes must leave the grid size alone
        write_reg(CFG_UNUSED_A, 9'h1FF);
        write_reg(CFG_UNUSED_B, 9'd0);
        enqueue(make_query(0, 0, 99, 0));
        wait_idle();

        write_reg(glc_pkg::CFG_GRID_WIDTH, 9'd32);
        write_reg(glc_pkg::CFG_GRID_HEIGHT, 9'd24);
        run_random(200, 32);

        write_reg(glc_pkg::CFG_GRID_WIDTH, 9'd256);
        write_reg(glc_pkg::CFG_GRID_HEIGHT, 9'd256);
        run_random(250, 64);

        write_reg(glc_pkg::CFG_GRID_WIDTH, 9'd1);
        write_reg(glc_pkg::CFG_GRID_HEIGHT, 9'd1);
        run_random(20, 8);

        for (int p = 0; p < 3; p++) begin
            write_reg(glc_pkg::CFG_GRID_WIDTH, cfg_t'($urandom_range(256, 1)));
            write_reg(glc_pkg::CFG_GRID_HEIGHT, cfg_t'($urandom_range(256, 1)));
            run_random(70, 64);
        end

        while (!(items_accepted == items_pushed && blocked_q.size() == 0)) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && blocked_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/glc_pkg.sv
rtl/glc_grid_mem.sv
rtl/grid_line_of_sight_check.sv
rtl/glc_checker.sv
sim/grid_line_of_sight_check_tb.sv
